>>> hw/rtl/spk_pkg.sv
package spk_pkg;

  localparam int WORD_W   = 32;
  localparam int BLOCK_W  = 2 * WORD_W;
  localparam int ACT_W    = 2;
  localparam int KIND_W   = 2;
  localparam int NUM_REGS = 6;
  localparam int CFG_AW   = 3;
  localparam int ROUNDS   = 27;
  localparam int RK_AW    = $clog2(ROUNDS);

  // rotate amounts of one speck round and their complements
  localparam int ROT_A  = 8;
  localparam int ROT_B  = 3;
  localparam int ROT_AC = WORD_W - ROT_A;
  localparam int ROT_BC = WORD_W - ROT_B;

  typedef enum logic [ACT_W-1:0] {
    ACT_ENC   = 2'd0,
    ACT_DEC   = 2'd1,
    ACT_START = 2'd2
  } spk_action_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_CIPHER = 2'd0,
    KIND_PLAIN  = 2'd1,
    KIND_START  = 2'd2
  } spk_kind_e;

  typedef enum logic [CFG_AW-1:0] {
    REG_KEY0    = 3'd0,
    REG_KEY1    = 3'd1,
    REG_KEY2    = 3'd2,
    REG_KEY3    = 3'd3,
    REG_IV_LOW  = 3'd4,
    REG_IV_HIGH = 3'd5
  } spk_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_KEYX = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_FIN  = 4'b1000
  } spk_state_e;

endpackage

>>> hw/rtl/spk_ram.sv
module spk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/speck64_128_cbc_cipher_unit.sv
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: block_low, block_high; tuser: action
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: out_low, out_high; tuser: out_kind
// cfg       in   cfg_we_i (no wait)            cfg_idx_i register index, cfg_data_i value
//
// an encrypt or decrypt request runs one round per cycle on the round datapath,
// fed by one key memory read per cycle, then the cbc xor step, which waits for
// a free output register; a start request runs the key expansion instead, then loads the iv
// an unused action code is accepted and gives no result
// reset clears control, config registers and the chaining value; round keys
// are undefined until the first start
// a result waiting on m_axis does not block the next request; only the final
// step of that next request waits for the output register to free up
module speck64_128_cbc_cipher_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [spk_pkg::CFG_AW-1:0]   cfg_idx_i,
  input  logic [spk_pkg::WORD_W-1:0]   cfg_data_i,
  // request stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [spk_pkg::BLOCK_W-1:0]  s_axis_tdata,  // [31:0] block_low, [63:32] block_high
  input  logic [spk_pkg::ACT_W-1:0]    s_axis_tuser,  // [1:0] action
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [spk_pkg::BLOCK_W-1:0]  m_axis_tdata,  // [31:0] out_low, [63:32] out_high
  output logic [spk_pkg::KIND_W-1:0]   m_axis_tuser   // [1:0] out_kind
);

  import spk_pkg::*;

  localparam logic [RK_AW-1:0] LAST_IDX = RK_AW'(ROUNDS - 1);
  localparam logic [RK_AW-1:0] FIRST_IDX = '0;

  // control state
  spk_state_e        state_q, state_d;
  logic [RK_AW-1:0]  cnt_q, cnt_d;
  spk_action_e       op_q, op_d;
  logic              m_valid_q, m_valid_d;

  // configuration registers and chaining value
  logic [WORD_W-1:0] cfg_q [NUM_REGS];
  logic [WORD_W-1:0] chain_lo_q, chain_lo_d;
  logic [WORD_W-1:0] chain_hi_q, chain_hi_d;

  // datapath registers
  logic [WORD_W-1:0]  x_q, x_d, y_q, y_d;
  logic [WORD_W-1:0]  cx_q, cx_d, cy_q, cy_d;
  logic [WORD_W-1:0]  k_q, k_d;
  logic [WORD_W-1:0]  lw_q [3];
  logic [WORD_W-1:0]  lw_d [3];
  logic [BLOCK_W-1:0] m_data_q, m_data_d;
  spk_kind_e          m_kind_q, m_kind_d;

  // key memory
  logic              ram_we;
  logic [RK_AW-1:0]  ram_raddr;
  logic [WORD_W-1:0] rk;

  // round datapath
  logic [WORD_W-1:0] enc_x, enc_y;
  logic [WORD_W-1:0] dec_t, dec_s, dec_x, dec_y;
  logic [WORD_W-1:0] ks_l, ks_k;

  logic s_fire, out_free, last_round;
  logic [WORD_W-1:0] blk_lo, blk_hi;

  spk_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROUNDS)
  ) u_rk_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q),
    .wdata_i (k_q),
    .raddr_i (ram_raddr),
    .rdata_o (rk)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign last_round    = (cnt_q == LAST_IDX);
  assign blk_lo        = s_axis_tdata[WORD_W-1:0];
  assign blk_hi        = s_axis_tdata[BLOCK_W-1:WORD_W];

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_kind_q;

  // forward round: x = (ror8(x) + y) ^ k, y = rol3(y) ^ x
  assign enc_x = ({x_q[ROT_A-1:0], x_q[WORD_W-1:ROT_A]} + y_q) ^ rk;
  assign enc_y = {y_q[ROT_BC-1:0], y_q[WORD_W-1:ROT_BC]} ^ enc_x;

  // inverse round: y = ror3(x ^ y), x = rol8((x ^ k) - y)
  assign dec_t = y_q ^ x_q;
  assign dec_y = {dec_t[ROT_B-1:0], dec_t[WORD_W-1:ROT_B]};
  assign dec_s = (x_q ^ rk) - dec_y;
  assign dec_x = {dec_s[ROT_AC-1:0], dec_s[WORD_W-1:ROT_AC]};

  // key schedule step, the three l words rotate through lw_q[0]
  assign ks_l = ({lw_q[0][ROT_A-1:0], lw_q[0][WORD_W-1:ROT_A]} + k_q)
                ^ {{(WORD_W-RK_AW){1'b0}}, cnt_q};
  assign ks_k = {k_q[ROT_BC-1:0], k_q[WORD_W-1:ROT_BC]} ^ ks_l;

  assign ram_we = (state_q == ST_KEYX);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    op_d       = op_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;
    m_kind_d   = m_kind_q;
    chain_lo_d = chain_lo_q;
    chain_hi_d = chain_hi_q;
    x_d        = x_q;
    y_d        = y_q;
    cx_d       = cx_q;
    cy_d       = cy_q;
    k_d        = k_q;
    lw_d       = lw_q;
    ram_raddr  = FIRST_IDX;

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          cnt_d = FIRST_IDX;
          cx_d  = blk_hi;
          cy_d  = blk_lo;
          unique case (s_axis_tuser)
            ACT_ENC: begin
              op_d    = ACT_ENC;
              x_d     = blk_hi ^ chain_hi_q;
              y_d     = blk_lo ^ chain_lo_q;
              state_d = ST_RUN;
            end
            ACT_DEC: begin
              // inverse rounds walk the keys from the top down
              op_d      = ACT_DEC;
              x_d       = blk_hi;
              y_d       = blk_lo;
              ram_raddr = LAST_IDX;
              state_d   = ST_RUN;
            end
            ACT_START: begin
              op_d     = ACT_START;
              k_d      = cfg_q[REG_KEY0];
              lw_d[0]  = cfg_q[REG_KEY1];
              lw_d[1]  = cfg_q[REG_KEY2];
              lw_d[2]  = cfg_q[REG_KEY3];
              state_d  = ST_KEYX;
            end
            default: begin
              // unused action code: dropped, the unit stays idle
            end
          endcase
        end
      end
      ST_KEYX: begin
        // round key cnt_q is k_q, written this cycle
        k_d     = ks_k;
        lw_d[0] = lw_q[1];
        lw_d[1] = lw_q[2];
        lw_d[2] = ks_l;
        cnt_d   = cnt_q + RK_AW'(1);
        if (last_round) begin
          state_d = ST_FIN;
        end
      end
      ST_RUN: begin
        // rk holds the key of this round; fetch the next one
        if (op_q == ACT_DEC) begin
          x_d = dec_x;
          y_d = dec_y;
          if (!last_round) begin
            ram_raddr = LAST_IDX - cnt_q - RK_AW'(1);
          end
        end else begin
          x_d = enc_x;
          y_d = enc_y;
          if (!last_round) begin
            ram_raddr = cnt_q + RK_AW'(1);
          end
        end
        cnt_d = cnt_q + RK_AW'(1);
        if (last_round) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // cbc step and hand-off to the output register
        if (out_free) begin
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
          unique case (op_q)
            ACT_ENC: begin
              m_data_d   = {x_q, y_q};
              m_kind_d   = KIND_CIPHER;
              chain_lo_d = y_q;
              chain_hi_d = x_q;
            end
            ACT_DEC: begin
              m_data_d   = {x_q ^ chain_hi_q, y_q ^ chain_lo_q};
              m_kind_d   = KIND_PLAIN;
              chain_lo_d = cy_q;
              chain_hi_d = cx_q;
            end
            ACT_START: begin
              m_data_d   = '0;
              m_kind_d   = KIND_START;
              chain_lo_d = cfg_q[REG_IV_LOW];
              chain_hi_d = cfg_q[REG_IV_HIGH];
            end
            default: begin
              m_data_d = '0;
              m_kind_d = KIND_START;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      op_q       <= ACT_ENC;
      m_valid_q  <= 1'b0;
      chain_lo_q <= '0;
      chain_hi_q <= '0;
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      op_q       <= op_d;
      m_valid_q  <= m_valid_d;
      chain_lo_q <= chain_lo_d;
      chain_hi_q <= chain_hi_d;
      // indexes past the register list are ignored
      if (cfg_we_i && (cfg_idx_i < CFG_AW'(NUM_REGS))) begin
        cfg_q[cfg_idx_i] <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    y_q      <= y_d;
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    k_q      <= k_d;
    lw_q     <= lw_d;
    m_data_q <= m_data_d;
    m_kind_q <= m_kind_d;
  end

  // a block request goes straight into the round loop
  a_block_to_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (s_axis_tuser == ACT_ENC || s_axis_tuser == ACT_DEC)
    |=> state_q == ST_RUN && cnt_q == FIRST_IDX)
    else $error("block request did not start the rounds");

  // the round counter never runs past the key memory
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN || state_q == ST_KEYX) |-> cnt_q <= LAST_IDX)
    else $error("round counter out of range");

  // a finished request with a free output register is presented next cycle
  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN && out_free |=> m_axis_tvalid && state_q == ST_IDLE)
    else $error("result not presented after final step");

  // the last round always hands over to the final step
  a_last_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN && last_round |=> state_q == ST_FIN)
    else $error("round loop did not end after the last round");

endmodule
